FILE: rtl/core/sample_frame_serializer_core_macros.svh
// Assertion macros shared by the serializer RTL.
`ifndef SAMPLE_FRAME_SERIALIZER_CORE_MACROS_SVH
`define SAMPLE_FRAME_SERIALIZER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SFS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sample_frame_serializer_core: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sample_frame_serializer_core: next-cycle check failed");

`endif

FILE: rtl/core/sfs_pkg.sv
// Shared types and constants for the sample frame serializer.
package sfs_pkg;

  localparam logic [15:0] MAGIC_RESET = 16'hABCD;

  // One classified sample waiting for the byte emitter.
  typedef struct packed {
    logic        header;   // first sample of a frame: send the header first
    logic        eof;      // last sample of a frame
    logic [15:0] magic;    // magic captured when the sample was taken
    logic [31:0] seq;      // sequence number for the header
    logic [15:0] sample;
  } entry_t;

endpackage

FILE: rtl/core/sfs_front.sv
// Front end: accepts samples, tracks frame position and sequence number.
module sfs_front #(
  parameter int SAMPLES_PER_FRAME = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write_enable,
  input  logic [15:0]    cfg_write_data,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [15:0]    sample,
  output logic           push_valid,
  input  logic           push_ready,
  output sfs_pkg::entry_t push_entry
);

  localparam int IDX_W = (SAMPLES_PER_FRAME > 1) ? $clog2(SAMPLES_PER_FRAME) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_FRAME - 1);

  logic [15:0]      magic_word;
  logic [IDX_W-1:0] sample_index;
  logic [31:0]      sequence_number;
  logic             first_sample;
  logic             last_sample;
  logic             accept;

  assign first_sample = (sample_index == '0);
  assign last_sample  = (sample_index == LAST_IDX);
  assign in_ready     = push_ready;
  assign push_valid   = in_valid;
  assign accept       = in_valid && push_ready;

  always_comb begin
    push_entry.header = first_sample;
    push_entry.eof    = last_sample;
    push_entry.magic  = magic_word;
    push_entry.seq    = sequence_number;
    push_entry.sample = sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word      <= sfs_pkg::MAGIC_RESET;
      sample_index    <= '0;
      sequence_number <= '0;
    end else begin
      if (cfg_write_enable) begin
        magic_word <= cfg_write_data;
      end
      if (accept) begin
        sample_index <= last_sample ? '0 : sample_index + IDX_W'(1);
        if (first_sample) begin
          sequence_number <= sequence_number + 32'd1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/sfs_queue.sv
// Two-entry queue between the front end and the byte emitter.
module sfs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  sfs_pkg::entry_t push_entry,
  output logic            pop_valid,
  input  logic            pop,
  output sfs_pkg::entry_t pop_entry
);

  sfs_pkg::entry_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign pop_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/sfs_back.sv
// Back end: walks each queued entry and emits its bytes, one per cycle while the receiver takes them.
module sfs_back #(
  parameter int SAMPLES_PER_FRAME = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  sfs_pkg::entry_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            last_of_item,
  output logic            end_of_frame
);

  localparam logic [15:0] FRAME_COUNT = 16'(SAMPLES_PER_FRAME);

  localparam logic [3:0] BYTE_MAGIC_LO  = 4'd0;
  localparam logic [3:0] BYTE_MAGIC_HI  = 4'd1;
  localparam logic [3:0] BYTE_COUNT_LO  = 4'd2;
  localparam logic [3:0] BYTE_COUNT_HI  = 4'd3;
  localparam logic [3:0] BYTE_SEQ_0     = 4'd4;
  localparam logic [3:0] BYTE_SEQ_1     = 4'd5;
  localparam logic [3:0] BYTE_SEQ_2     = 4'd6;
  localparam logic [3:0] BYTE_SEQ_3     = 4'd7;
  localparam logic [3:0] BYTE_SAMPLE_LO = 4'd8;
  localparam logic [3:0] BYTE_SAMPLE_HI = 4'd9;
  localparam logic [3:0] SAMPLE_ONLY_LAST = 4'd1;

  logic [3:0] pos;       // bytes already sent for the head entry
  logic [3:0] byte_sel;
  logic [7:0] byte_val;
  logic       is_last;
  logic       load;

  assign byte_sel = head.header ? pos : pos + BYTE_SAMPLE_LO;
  assign is_last  = head.header ? (pos == BYTE_SAMPLE_HI) : (pos == SAMPLE_ONLY_LAST);
  assign load     = head_valid && (!out_valid || out_ready);
  assign pop      = load && is_last;

  always_comb begin
    case (byte_sel)
      BYTE_MAGIC_LO:  byte_val = head.magic[7:0];
      BYTE_MAGIC_HI:  byte_val = head.magic[15:8];
      BYTE_COUNT_LO:  byte_val = FRAME_COUNT[7:0];
      BYTE_COUNT_HI:  byte_val = FRAME_COUNT[15:8];
      BYTE_SEQ_0:     byte_val = head.seq[7:0];
      BYTE_SEQ_1:     byte_val = head.seq[15:8];
      BYTE_SEQ_2:     byte_val = head.seq[23:16];
      BYTE_SEQ_3:     byte_val = head.seq[31:24];
      BYTE_SAMPLE_LO: byte_val = head.sample[7:0];
      BYTE_SAMPLE_HI: byte_val = head.sample[15:8];
      default:        byte_val = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= 4'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        pos       <= is_last ? 4'd0 : pos + 4'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= byte_val;
      last_of_item <= is_last;
      end_of_frame <= is_last && head.eof;
    end
  end

endmodule

FILE: rtl/core/sample_frame_serializer_core.sv
// Top level of the sample frame serializer: front end, queue and byte emitter.
//
// Input channel: one 16-bit sample per beat (in_valid/in_ready, sample).
// Output channel: one wire byte per beat (out_valid/out_ready, out_byte,
// last_of_item, end_of_frame), little-endian. The first sample of a frame
// brings an 8-byte header (magic, sample count, 32-bit sequence number)
// ahead of its two bytes; every other sample brings two bytes.
// With the pipe empty, a sample is first written into the queue and its first
// byte is then registered in the output register of the emitter.
// Throughput: one output byte per cycle while the receiver takes every byte,
// set by the single byte register of the emitter.
// A two-entry queue lets the front take samples while the emitter works, so
// input stalls only while the queue is full.
// The magic register is written with cfg_write_enable/cfg_write_data and is
// captured with each frame's first sample.
// Reset (rst, synchronous): empties the queue, drops any byte on the output,
// restores magic 0xABCD and clears frame position and sequence number.
// When the receiver stalls, the output byte holds, the queue fills and then
// in_ready drops; nothing is lost.
module sample_frame_serializer_core #(
  parameter int SAMPLES_PER_FRAME = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_of_item,
  output logic        end_of_frame
);

`include "sample_frame_serializer_core_macros.svh"

  // Front to queue
  logic            q_push_valid;
  logic            q_push_ready;
  sfs_pkg::entry_t q_push_entry;

  // Queue to emitter
  logic            q_pop_valid;
  logic            q_pop;
  sfs_pkg::entry_t q_head;

  // Classify each sample: header or not, end of frame, and capture magic
  // and sequence number for its header.
  sfs_front #(
    .SAMPLES_PER_FRAME(SAMPLES_PER_FRAME)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_enable(cfg_write_enable),
    .cfg_write_data  (cfg_write_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample          (sample),
    .push_valid      (q_push_valid),
    .push_ready      (q_push_ready),
    .push_entry      (q_push_entry)
  );

  // Decouple: hold up to two classified samples.
  sfs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(q_push_valid),
    .push_ready(q_push_ready),
    .push_entry(q_push_entry),
    .pop_valid (q_pop_valid),
    .pop       (q_pop),
    .pop_entry (q_head)
  );

  // Advance through the head entry one byte per output beat.
  sfs_back #(
    .SAMPLES_PER_FRAME(SAMPLES_PER_FRAME)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (q_pop_valid),
    .head        (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_item(last_of_item),
    .end_of_frame(end_of_frame)
  );

  // A frame ends only on the last byte of a sample.
  `SFS_ASSERT_NOW(a_eof_on_last, clk, rst, out_valid && end_of_frame, last_of_item)
  // A sample beat leaves the queue non-empty on the next cycle.
  `SFS_ASSERT_NEXT(a_push_fills, clk, rst, in_valid && in_ready, q_pop_valid)
  // The emitter never pops an empty queue.
  `SFS_ASSERT_NOW(a_pop_nonempty, clk, rst, q_pop, q_pop_valid)

endmodule

FILE: bench/sample_frame_serializer_core_tb.sv
// Self-checking testbench for the sample frame serializer.
module sample_frame_serializer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_LEN     = 32;
  // Cycles with no beat on either channel before the run is declared hung.
  localparam int IDLE_LIMIT    = 3000;
  // Length of the one deliberate receiver hold-off; must fill the queue.
  localparam int LONG_HOLD     = 400;
  localparam int DRAIN_CYCLES  = 8;

  // One byte on the wire, with its two marker bits.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eof;
  } wire_byte_t;

  // Predicts the byte stream of each accepted sample and checks the output
  // beats against it in order.
  class frame_scoreboard;
    logic [15:0]  magic;
    int unsigned  sample_pos;
    logic [31:0]  seq_no;
    wire_byte_t   pending_bytes[$];
    int unsigned  errors;

    function new();
      magic      = sfs_pkg::MAGIC_RESET;
      sample_pos = 0;
      seq_no     = '0;
      errors     = 0;
    endfunction

    function void set_magic(logic [15:0] value);
      magic = value;
    endfunction

    function void push_byte(logic [7:0] data, logic last, logic eof);
      wire_byte_t b;
      b.data = data;
      b.last = last;
      b.eof  = eof;
      pending_bytes.push_back(b);
    endfunction

    // Queue the bytes one accepted sample brings: the header first when it
    // opens a frame, then the sample low byte first.
    function void note_sample(logic [15:0] s);
      logic [15:0] count;
      logic        eof;
      count = 16'(FRAME_LEN);
      if (sample_pos == 0) begin
        push_byte(magic[7:0], 1'b0, 1'b0);
        push_byte(magic[15:8], 1'b0, 1'b0);
        push_byte(count[7:0], 1'b0, 1'b0);
        push_byte(count[15:8], 1'b0, 1'b0);
        push_byte(seq_no[7:0], 1'b0, 1'b0);
        push_byte(seq_no[15:8], 1'b0, 1'b0);
        push_byte(seq_no[23:16], 1'b0, 1'b0);
        push_byte(seq_no[31:24], 1'b0, 1'b0);
        seq_no = seq_no + 32'd1;
      end
      sample_pos = sample_pos + 1;
      eof = 1'b0;
      if (sample_pos >= FRAME_LEN) begin
        sample_pos = 0;
        eof = 1'b1;
      end
      push_byte(s[7:0], 1'b0, 1'b0);
      push_byte(s[15:8], 1'b1, eof);
    endfunction

    function void check_byte(logic [7:0] data, logic last, logic eof);
      wire_byte_t exp_b;
      if (pending_bytes.size() == 0) begin
        $display("%0t: byte with nothing expected: out_byte=%02h last=%0b eof=%0b",
                 $time, data, last, eof);
        errors++;
        return;
      end
      exp_b = pending_bytes.pop_front();
      if (data !== exp_b.data) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, exp_b.data, data);
        errors++;
      end
      if (last !== exp_b.last) begin
        $display("%0t: last_of_item expected %0b actual %0b", $time, exp_b.last, last);
        errors++;
      end
      if (eof !== exp_b.eof) begin
        $display("%0t: end_of_frame expected %0b actual %0b", $time, exp_b.eof, eof);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_enable = 1'b0;
  logic [15:0] cfg_write_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] sample = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        last_of_item;
  logic        end_of_frame;

  frame_scoreboard sb;

  // When set, neither side idles: back-to-back beats at full rate.
  logic        calm = 1'b1;
  int          idle_cycles = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  // Raised by the stimulus at the start of a busy phase to start the hold-off.
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;

  sample_frame_serializer_core #(
    .SAMPLES_PER_FRAME(FRAME_LEN)
  ) DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_enable(cfg_write_enable),
    .cfg_write_data  (cfg_write_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample          (sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .last_of_item    (last_of_item),
    .end_of_frame    (end_of_frame)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Random sample, biased a little toward all-zero / all-one patterns.
  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    if (r == 2) return 16'h00FF;
    if (r == 3) return 16'hFF00;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Offer one sample after an optional gap and hold it until the beat.
  // Valid is left high after the beat so a back-to-back sample never
  // lowers and raises it in the same step.
  task automatic send_sample(logic [15:0] s);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(s);
  endtask

  // Drop valid after the last sample of a phase and wait for every byte.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the magic register while the block is idle.
  task automatic write_magic(logic [15:0] value);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= value;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    sb.set_magic(value);
    @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off while the sender keeps
  // offering, so the queue fills and in_ready has to drop.
  always @(posedge clk) begin
    int g;
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && hold_req) begin
      out_ready <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      g = calm ? 0 : pick_gap();
      if (g == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left <= g - 1;
      end
    end
  end

  // Check every output beat against the oldest expected byte.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_byte(out_byte, last_of_item, end_of_frame);
    end
  end

  // Hang detection: count cycles with no beat on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, idle_cycles);
      $display("sample_frame_serializer_core regression: fail");
      $finish;
    end
  end

  initial begin
    logic [15:0] directed[$];
    logic [15:0] magics[$];
    int n;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset magic in the first header, sample extremes and
    // single-bit patterns, back to back with no idling.
    directed = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h0001, 16'h8000,
                 16'hAAAA, 16'h5555, 16'h7FFF, 16'hFFFE, 16'h0100, 16'h0080,
                 16'h1234, 16'hFEDC, 16'h8001, 16'h7FFE, 16'h00FF, 16'hFF00,
                 16'h0F0F, 16'hF0F0};
    calm = 1'b1;
    foreach (directed[i]) send_sample(directed[i]);
    drain();

    // Random phases. The first magic write lands mid-frame, so the new value
    // must show only in the next header. Extremes first, then random values,
    // and one calm phase to run at full rate. The long hold-off starts with
    // the third phase, while its samples are still being offered.
    magics = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00};
    for (int p = 0; p < 8; p++) begin
      if (p < magics.size()) write_magic(magics[p]);
      else write_magic(16'($urandom_range(0, 65535)));
      calm = (p == 5);
      if (p == 2) hold_req <= 1'b1;
      n = $urandom_range(15, 35);
      for (int i = 0; i < n; i++) send_sample(pick_sample());
      drain();
    end

    if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
      $display("sample_frame_serializer_core regression: pass");
    end else begin
      if (sb.pending_bytes.size() != 0)
        $display("%0t: %0d expected bytes never arrived", $time, sb.pending_bytes.size());
      $display("sample_frame_serializer_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: sample_frame_serializer_core.f
+incdir+rtl/core
rtl/core/sfs_pkg.sv
rtl/core/sfs_front.sv
rtl/core/sfs_queue.sv
rtl/core/sfs_back.sv
rtl/core/sample_frame_serializer_core.sv
bench/sample_frame_serializer_core_tb.sv
